>>> rtl/core/emq_pkg.sv
package emq_pkg;

  // store geometry
  localparam int CAPACITY    = 32;
  localparam int HANDLE_BITS = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // fixed port widths
  localparam int HANDLE_OUT_W = 16;
  localparam int COUNT_OUT_W  = 6;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_EXTRACT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NO_MATCH = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_READ,
    S_CMP,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [15:0] comm;
    logic [15:0] rank;
    logic [63:0] tag;
  } key_t;

  typedef struct packed {
    key_t                   key;
    logic [HANDLE_BITS-1:0] handle;
  } slot_t;

  // one write and one read port of the slot store
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    slot_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

>>> rtl/core/early_message_match_queue.sv
// enqueue: result pushed from S_RESP, next request accepted after that
// dequeue and extract: one scan of all held entries, each read in S_READ and
//   compared in S_CMP, then the final result from S_FIN
// the scan rate is set by the single store read port and the one key comparator
// output stalls pause the scan; the store is compacted during the same pass
// reset clears the count and all control state; slot contents are not cleared
module early_message_match_queue
  import emq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              operation_i,
  input  logic [15:0]             comm_id_i,
  input  logic [15:0]             source_rank_i,
  input  logic signed [63:0]      message_tag_i,
  input  logic [15:0]             request_handle_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    found_o,
  output logic [HANDLE_OUT_W-1:0] handle_out_o,
  output logic [1:0]              status_o,
  output logic [COUNT_OUT_W-1:0]  stored_count_o,
  output logic                    last_o
);

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0]       cnt_start_q, cnt_start_d;
  logic [CNT_W-1:0]       rd_q, rd_d;
  logic [CNT_W-1:0]       wr_q, wr_d;
  logic [CNT_W-1:0]       matches_q, matches_d;
  logic                   pend_valid_q, pend_valid_d;
  logic [HANDLE_BITS-1:0] pend_handle_q, pend_handle_d;
  logic [CNT_W-1:0]       pend_count_q, pend_count_d;
  logic [1:0]             op_q, op_d;
  key_t                   key_q, key_d;
  status_e                resp_status_q, resp_status_d;

  logic                    out_valid_q, out_valid_d;
  logic                    out_found_q;
  logic [HANDLE_OUT_W-1:0] out_handle_q;
  status_e                 out_status_q;
  logic [COUNT_OUT_W-1:0]  out_count_q;
  logic                    out_last_q;

  logic                   push;
  logic                   push_found;
  logic [HANDLE_BITS-1:0] push_handle;
  status_e                push_status;
  logic [CNT_W-1:0]       push_count;
  logic                   push_last;
  logic                   can_push;
  logic                   advance;

  mem_req_t mem_req;
  slot_t    rd_data;
  logic     key_match;
  logic     hit;

  // slot store
  emq_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // shared key comparator
  emq_key_cmp u_key_cmp (
    .entry_key_i (rd_data.key),
    .req_key_i   (key_q),
    .match_o     (key_match)
  );

  assign can_push   = !out_valid_q || !out_stall_i;
  assign hit        = key_match && !((op_q == OP_DEQUEUE) && (matches_q != '0));
  assign in_stall_o = (state_q != S_IDLE);

  // sequencer: next state, store access and result push
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cnt_start_d   = cnt_start_q;
    rd_d          = rd_q;
    wr_d          = wr_q;
    matches_d     = matches_q;
    pend_valid_d  = pend_valid_q;
    pend_handle_d = pend_handle_q;
    pend_count_d  = pend_count_q;
    op_d          = op_q;
    key_d         = key_q;
    resp_status_d = resp_status_q;
    mem_req       = '0;
    push          = 1'b0;
    push_found    = 1'b0;
    push_handle   = '0;
    push_status   = STAT_OK;
    push_count    = cnt_q;
    push_last     = 1'b1;
    advance       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = operation_i;
          key_d.comm   = comm_id_i;
          key_d.rank   = source_rank_i;
          key_d.tag    = message_tag_i;
          cnt_start_d  = cnt_q;
          rd_d         = '0;
          wr_d         = '0;
          matches_d    = '0;
          pend_valid_d = 1'b0;
          unique case (operation_i) inside
            OP_ENQUEUE: begin
              state_d = S_RESP;
              if (cnt_q == CNT_W'(CAPACITY)) begin
                resp_status_d = STAT_FULL;
              end else begin
                mem_req.we                = 1'b1;
                mem_req.waddr             = cnt_q[IDX_W-1:0];
                mem_req.wdata.key.comm    = comm_id_i;
                mem_req.wdata.key.rank    = source_rank_i;
                mem_req.wdata.key.tag     = message_tag_i;
                mem_req.wdata.handle      = HANDLE_BITS'(request_handle_i);
                cnt_d                     = cnt_q + CNT_W'(1);
                resp_status_d             = STAT_OK;
              end
            end
            OP_DEQUEUE, OP_EXTRACT: begin
              if (cnt_q == '0) begin
                resp_status_d = STAT_NO_MATCH;
                state_d       = S_RESP;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              resp_status_d = STAT_OK;
              state_d       = S_RESP;
            end
          endcase
        end
      end

      // single result of enqueue, empty search or unused code
      S_RESP: begin
        if (can_push) begin
          push        = 1'b1;
          push_status = resp_status_q;
          push_count  = cnt_q;
          state_d     = S_IDLE;
        end
      end

      S_READ: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = rd_q[IDX_W-1:0];
        state_d       = S_CMP;
      end

      // compare one entry: a hit is taken out, a miss is written back compacted
      S_CMP: begin
        if (hit) begin
          if (!pend_valid_q || can_push) begin
            if (pend_valid_q) begin
              push        = 1'b1;
              push_found  = 1'b1;
              push_handle = pend_handle_q;
              push_count  = pend_count_q;
              push_last   = 1'b0;
            end
            pend_valid_d  = 1'b1;
            pend_handle_d = rd_data.handle;
            pend_count_d  = cnt_start_q - matches_q - CNT_W'(1);
            matches_d     = matches_q + CNT_W'(1);
            advance       = 1'b1;
          end
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = wr_q[IDX_W-1:0];
          mem_req.wdata = rd_data;
          wr_d          = wr_q + CNT_W'(1);
          advance       = 1'b1;
        end
        if (advance) begin
          rd_d    = rd_q + CNT_W'(1);
          state_d = ((rd_q + CNT_W'(1)) == cnt_start_q) ? S_FIN : S_READ;
        end
      end

      // final result of the scan
      S_FIN: begin
        if (can_push) begin
          push = 1'b1;
          if (pend_valid_q) begin
            push_found  = 1'b1;
            push_handle = pend_handle_q;
            push_count  = pend_count_q;
          end else begin
            push_status = STAT_NO_MATCH;
            push_count  = cnt_q;
          end
          cnt_d   = cnt_start_q - matches_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // output register handshake
  always_comb begin
    if (push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // request and scan payload
  always_ff @(posedge clk_i) begin
    cnt_start_q   <= cnt_start_d;
    rd_q          <= rd_d;
    wr_q          <= wr_d;
    matches_q     <= matches_d;
    pend_handle_q <= pend_handle_d;
    pend_count_q  <= pend_count_d;
    op_q          <= op_d;
    key_q         <= key_d;
    resp_status_q <= resp_status_d;
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      out_found_q  <= push_found;
      out_handle_q <= HANDLE_OUT_W'(push_handle);
      out_status_q <= push_status;
      out_count_q  <= COUNT_OUT_W'(push_count);
      out_last_q   <= push_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign handle_out_o   = out_handle_q;
  assign status_o       = out_status_q;
  assign stored_count_o = out_count_q;
  assign last_o         = out_last_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (wr_q <= rd_q) && (rd_q < cnt_start_q))
    else $error("compaction write pointer ahead of read pointer");

  a_match_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP || state_q == S_FIN) |-> (matches_q <= cnt_start_q))
    else $error("more matches than scanned entries");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (status_o == STAT_OK))
    else $error("matched handle with error status");

endmodule

>>> rtl/core/emq_store.sv
module emq_store
  import emq_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output slot_t    rd_data_o
);

  slot_t mem_q [CAPACITY];
  slot_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/emq_key_cmp.sv
module emq_key_cmp
  import emq_pkg::*;
(
  input  key_t entry_key_i,
  input  key_t req_key_i,
  output logic match_o
);

  // exact match on communicator, rank and all tag bits
  assign match_o = (entry_key_i.comm == req_key_i.comm) &&
                   (entry_key_i.rank == req_key_i.rank) &&
                   (entry_key_i.tag  == req_key_i.tag);

endmodule
